// ===== hw/rtl/xor_checked_frame_builder_unit_assert.svh =====
// Assertion macros used by the frame builder serializer.
`ifndef XOR_CHECKED_FRAME_BUILDER_UNIT_ASSERT_SVH
`define XOR_CHECKED_FRAME_BUILDER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// Clocked on clk, silenced while rst_n is low.
`define XCFB_ASSERT(name, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("xcfb assertion failed");
// Clocked on clk, also checked during reset.
`define XCFB_ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("xcfb assertion failed");
`else
`define XCFB_ASSERT(name, prop)
`define XCFB_ASSERT_ALWAYS(name, prop)
`endif
`endif

// ===== hw/rtl/xcfb_pkg.sv =====
// Types and constants of the XOR-checked frame builder.
package xcfb_pkg;

  localparam int BYTE_W    = 8;
  localparam int LEN_W     = 16;
  localparam int CFG_IDX_W = 8;
  localparam int SLOT_W    = 4;

  // operation codes
  localparam logic OP_START   = 1'b0;
  localparam logic OP_PAYLOAD = 1'b1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HEADER_FIRST  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEADER_SECOND = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FOOTER_FIRST  = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FOOTER_SECOND = 8'd3;

  // byte positions within a frame; a payload byte travels in the length-low slot
  localparam logic [SLOT_W-1:0] SLOT_HDR_FIRST  = 4'd0;
  localparam logic [SLOT_W-1:0] SLOT_HDR_SECOND = 4'd1;
  localparam logic [SLOT_W-1:0] SLOT_TYPE       = 4'd2;
  localparam logic [SLOT_W-1:0] SLOT_COMMAND    = 4'd3;
  localparam logic [SLOT_W-1:0] SLOT_STATUS     = 4'd4;
  localparam logic [SLOT_W-1:0] SLOT_LEN_HIGH   = 4'd5;
  localparam logic [SLOT_W-1:0] SLOT_LEN_LOW    = 4'd6;
  localparam logic [SLOT_W-1:0] SLOT_CHECKSUM   = 4'd7;
  localparam logic [SLOT_W-1:0] SLOT_FTR_FIRST  = 4'd8;
  localparam logic [SLOT_W-1:0] SLOT_FTR_SECOND = 4'd9;

  typedef struct packed {
    logic              operation;
    logic [BYTE_W-1:0] frame_type;
    logic [BYTE_W-1:0] command_code;
    logic [BYTE_W-1:0] status_byte;
    logic [LEN_W-1:0]  payload_length;
    logic [BYTE_W-1:0] payload_byte;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] frame_byte;
    logic              run_end;
    logic              frame_end;
  } out_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] header_first;
    logic [BYTE_W-1:0] header_second;
    logic [BYTE_W-1:0] footer_first;
    logic [BYTE_W-1:0] footer_second;
  } frame_cfg_t;

  // one run of frame bytes, from first_slot to last_slot inclusive
  typedef struct packed {
    logic [SLOT_W-1:0] first_slot;
    logic [SLOT_W-1:0] last_slot;
    logic [BYTE_W-1:0] frame_type;
    logic [BYTE_W-1:0] command_code;
    logic [BYTE_W-1:0] status_byte;
    logic [BYTE_W-1:0] len_high;
    logic [BYTE_W-1:0] len_low;
    logic [BYTE_W-1:0] checksum;
  } burst_t;

  typedef struct packed {
    logic   emit;
    burst_t burst;
  } burst_req_t;

endpackage

// ===== hw/rtl/xcfb_frame_ctl.sv =====
// Frame state: bytes left, running checksum, open flag; turns a request into a byte run.
module xcfb_frame_ctl import xcfb_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  in_item_t   item,
  output burst_req_t req
);

  logic [LEN_W-1:0]  bytes_left_r, bytes_left_nxt;
  logic [BYTE_W-1:0] running_xor_r, running_xor_nxt;
  logic              frame_open_r, frame_open_nxt;

  logic [BYTE_W-1:0] len_high;
  logic [BYTE_W-1:0] len_low;
  logic [BYTE_W-1:0] start_xor;
  logic [BYTE_W-1:0] payload_xor;
  logic [LEN_W-1:0]  left_dec;

  assign len_high    = item.payload_length[LEN_W-1:BYTE_W];
  assign len_low     = item.payload_length[BYTE_W-1:0];
  assign start_xor   = item.frame_type ^ item.command_code ^ item.status_byte
                     ^ len_high ^ len_low;
  assign payload_xor = running_xor_r ^ item.payload_byte;
  assign left_dec    = bytes_left_r - LEN_W'(1);

  always_comb begin
    bytes_left_nxt         = bytes_left_r;
    running_xor_nxt        = running_xor_r;
    frame_open_nxt         = frame_open_r;
    req                    = '0;
    req.burst.frame_type   = item.frame_type;
    req.burst.command_code = item.command_code;
    req.burst.status_byte  = item.status_byte;
    req.burst.len_high     = len_high;
    if (item.operation == OP_START) begin
      req.emit             = 1'b1;
      req.burst.first_slot = SLOT_HDR_FIRST;
      req.burst.last_slot  = (item.payload_length == '0) ? SLOT_FTR_SECOND : SLOT_LEN_LOW;
      req.burst.len_low    = len_low;
      req.burst.checksum   = start_xor;
      running_xor_nxt      = start_xor;
      bytes_left_nxt       = item.payload_length;
      frame_open_nxt       = (item.payload_length != '0);
    end else if (frame_open_r && (bytes_left_r != '0)) begin
      req.emit             = 1'b1;
      req.burst.first_slot = SLOT_LEN_LOW;
      req.burst.last_slot  = (left_dec == '0) ? SLOT_FTR_SECOND : SLOT_LEN_LOW;
      req.burst.len_low    = item.payload_byte;
      req.burst.checksum   = payload_xor;
      running_xor_nxt      = payload_xor;
      bytes_left_nxt       = left_dec;
      frame_open_nxt       = (left_dec != '0);
    end
    // otherwise drop a payload byte that has no open frame
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_left_r  <= '0;
      running_xor_r <= '0;
      frame_open_r  <= 1'b0;
    end else if (accept) begin
      bytes_left_r  <= bytes_left_nxt;
      running_xor_r <= running_xor_nxt;
      frame_open_r  <= frame_open_nxt;
    end
  end

endmodule

// ===== hw/rtl/xcfb_serializer.sv =====
// Byte run register and output register: walks a run one frame byte per cycle unless out_ready stalls it.
module xcfb_serializer import xcfb_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  burst_req_t req,
  input  frame_cfg_t cfg,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  output out_item_t  out_data
);

`include "xor_checked_frame_builder_unit_assert.svh"

  logic              bval_r;
  burst_t            burst_r;
  logic [SLOT_W-1:0] slot_r;
  logic              oval_r;
  out_item_t         out_r;

  logic              last_byte;
  logic              out_load;
  logic [BYTE_W-1:0] byte_sel;

  assign last_byte = (slot_r == burst_r.last_slot);
  assign out_load  = bval_r && (!oval_r || out_ready);
  // take the next request as the current run hands over its last byte
  assign in_ready  = !bval_r || (out_load && last_byte);

  always_comb begin
    unique case (slot_r)
      SLOT_HDR_FIRST:  byte_sel = cfg.header_first;
      SLOT_HDR_SECOND: byte_sel = cfg.header_second;
      SLOT_TYPE:       byte_sel = burst_r.frame_type;
      SLOT_COMMAND:    byte_sel = burst_r.command_code;
      SLOT_STATUS:     byte_sel = burst_r.status_byte;
      SLOT_LEN_HIGH:   byte_sel = burst_r.len_high;
      SLOT_LEN_LOW:    byte_sel = burst_r.len_low;
      SLOT_CHECKSUM:   byte_sel = burst_r.checksum;
      SLOT_FTR_FIRST:  byte_sel = cfg.footer_first;
      SLOT_FTR_SECOND: byte_sel = cfg.footer_second;
      default:         byte_sel = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bval_r <= 1'b0;
      oval_r <= 1'b0;
    end else begin
      if (accept) begin
        bval_r <= req.emit;
      end else if (out_load && last_byte) begin
        bval_r <= 1'b0;
      end
      if (out_load) begin
        oval_r <= 1'b1;
      end else if (out_ready) begin
        oval_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && req.emit) begin
      burst_r <= req.burst;
      slot_r  <= req.burst.first_slot;
    end else if (out_load) begin
      slot_r  <= slot_r + SLOT_W'(1);
    end
    if (out_load) begin
      out_r.frame_byte <= byte_sel;
      out_r.run_end    <= last_byte;
      out_r.frame_end  <= (slot_r == SLOT_FTR_SECOND);
    end
  end

  assign out_valid = oval_r;
  assign out_data  = out_r;

  `XCFB_ASSERT(a_slot_in_run, bval_r |-> (slot_r <= burst_r.last_slot))
  `XCFB_ASSERT(a_run_continues, (out_load && !last_byte && !accept) |=> bval_r)
  `XCFB_ASSERT(a_frame_end_ends_run, (oval_r && out_r.frame_end) |-> out_r.run_end)
  `XCFB_ASSERT_ALWAYS(a_reset_empties, !rst_n |=> (!oval_r && !bval_r))

endmodule

// ===== hw/rtl/xor_checked_frame_builder_unit.sv =====
// Top level of the XOR-checked frame builder: registers, frame state and byte serializer.
//
//   channel | direction | handshake             | payload
//   in_     | in        | in_valid / in_ready   | in_data (in_item_t)
//   out_    | out       | out_valid / out_ready | out_data (out_item_t)
//   cfg_    | in        | cfg_valid / cfg_ready | cfg_index, cfg_wdata
//
// Each request becomes a run of frame bytes that leave one per cycle unless out_ready
// stalls them: a start gives 7 bytes (10 with a zero length), a payload byte 1 (4 when
// it closes the frame). The next request is taken as a run hands over its last byte,
// so payload bytes stream at one per cycle. Reset is synchronous and clears the frame
// state and both valid flags; out_ready low stalls in_ready while a run is pending.
module xor_checked_frame_builder_unit import xcfb_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BYTE_W-1:0]    cfg_wdata
);

  frame_cfg_t cfg_r;
  burst_req_t req;
  logic       accept;

  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_HEADER_FIRST:  cfg_r.header_first  <= cfg_wdata;
        REG_HEADER_SECOND: cfg_r.header_second <= cfg_wdata;
        REG_FOOTER_FIRST:  cfg_r.footer_first  <= cfg_wdata;
        REG_FOOTER_SECOND: cfg_r.footer_second <= cfg_wdata;
        default: ; // drop writes beyond the register list
      endcase
    end
  end

  xcfb_frame_ctl u_frame_ctl (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .item   (in_data),
    .req    (req)
  );

  xcfb_serializer u_serializer (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .req       (req),
    .cfg       (cfg_r),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
